// File: rtl/slpd_pkg.sv
// Package for the sync/length packet deframer.
// Holds the sync and type constants and the result record shared by the parser,
// the output stage and the top level. No dependencies.
package slpd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h41;
  localparam logic [7:0] SYNC_SECOND = 8'h56;
  localparam logic [7:0] AMP_TYPE    = 8'h01;

  localparam int unsigned DATA_W = 48;

  typedef struct packed {
    logic        amplitude_valid;
    logic [15:0] amplitude;
    logic [7:0]  trailer_value;
    logic [15:0] payload_length;
    logic [7:0]  frame_type;
  } result_t;

endpackage

// File: rtl/sync_length_packet_deframer.sv
// Top level of the sync/length packet deframer.
// Instantiates slpd_in_reg, slpd_parser and slpd_out_reg; uses slpd_pkg.
//
// The slave channel takes one received serial byte per transfer. The block
// drops bytes until it sees the sync pair 'A','V', then reads a type byte, a
// 16-bit payload length (low byte first), the payload and one trailer byte.
// The transfer that carries the trailer byte makes one frame record on the
// master channel: type, length, trailer and, for type 1 with at least two
// payload bytes, the little-endian amplitude from the first two payload bytes
// with its valid flag in tuser. All other bytes make no record.
// Throughput is one byte per cycle while no trailer byte waits for the output
// register. A record reaches the master side by way of the input register, which
// holds the trailer byte, and then the output register, which holds the
// record. Reset returns the parser to sync hunting and
// empties both registers. While the receiver stalls, the record holds and
// header and payload bytes keep flowing; only the next trailer byte waits in
// the input register until the output register frees up.
module sync_length_packet_deframer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [slpd_pkg::DATA_W-1:0]  m_tdata,  // [7:0] frame_type, [23:8] payload_length,
                                                 // [31:24] trailer_value, [47:32] amplitude
  output logic [0:0]                   m_tuser   // [0] amplitude_valid
);

  logic              byte_valid;
  logic [7:0]        byte_data;
  logic              byte_take;
  logic              res_ready;
  logic              res_load;
  slpd_pkg::result_t res;

  slpd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take)
  );

  slpd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take),
    .res_ready  (res_ready),
    .res_load   (res_load),
    .res        (res)
  );

  slpd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .res_ready (res_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// File: rtl/slpd_in_reg.sv
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on nothing but the clock and reset.
module slpd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       byte_valid,
  output logic [7:0] byte_data,
  input  logic       byte_take
);

  logic       valid;
  logic [7:0] data;

  assign s_tready   = !valid || byte_take;
  assign byte_valid = valid;
  assign byte_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data <= s_tdata;
    end
  end

endmodule

// File: rtl/slpd_parser.sv
// Frame parser of the deframer: sync hunt, header fields, payload count and trailer.
// Uses slpd_pkg for the sync and type constants and the result record.
module slpd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  input  logic [7:0]       byte_data,
  output logic             byte_take,
  input  logic             res_ready,
  output logic             res_load,
  output slpd_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_HUNT_A  = 3'd0,
    PH_HUNT_V  = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_TRAILER = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [15:0] length, length_next;
  logic [15:0] count, count_next;
  logic [15:0] amp, amp_next;
  logic [15:0] count_inc;
  logic [15:0] full_length;
  logic        amp_ok;

  assign count_inc   = count + 16'd1;
  assign full_length = {byte_data, length[7:0]};

  // Only the trailer byte needs room in the output stage; other bytes always move.
  assign byte_take = byte_valid && ((phase != PH_TRAILER) || res_ready);
  assign res_load  = byte_valid && (phase == PH_TRAILER) && res_ready;

  assign amp_ok = (frame_type == slpd_pkg::AMP_TYPE) && (length >= 16'd2);

  always_comb begin
    res.frame_type      = frame_type;
    res.payload_length  = length;
    res.trailer_value   = byte_data;
    res.amplitude       = amp_ok ? amp : 16'd0;
    res.amplitude_valid = amp_ok;
  end

  always_comb begin
    phase_next      = phase;
    frame_type_next = frame_type;
    length_next     = length;
    count_next      = count;
    amp_next        = amp;
    case (phase)
      PH_HUNT_V: begin
        if (byte_data == slpd_pkg::SYNC_SECOND) begin
          phase_next = PH_TYPE;
        end else if (byte_data == slpd_pkg::SYNC_FIRST) begin
          phase_next = PH_HUNT_V;
        end else begin
          phase_next = PH_HUNT_A;
        end
      end
      PH_TYPE: begin
        frame_type_next = byte_data;
        phase_next      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_next = {8'd0, byte_data};
        phase_next  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_next = full_length;
        count_next  = 16'd0;
        amp_next    = 16'd0;
        phase_next  = (full_length == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (count == 16'd0) begin
          amp_next = {8'd0, byte_data};
        end else if (count == 16'd1) begin
          amp_next = {byte_data, amp[7:0]};
        end
        count_next = count_inc;
        if (count_inc >= length) begin
          phase_next = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        phase_next = PH_HUNT_A;
      end
      default: begin
        // Hunting for the first sync byte; the unused code behaves the same way.
        phase_next = (byte_data == slpd_pkg::SYNC_FIRST) ? PH_HUNT_V : PH_HUNT_A;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT_A;
      frame_type <= 8'd0;
      length     <= 16'd0;
      count      <= 16'd0;
      amp        <= 16'd0;
    end else if (byte_take) begin
      phase      <= phase_next;
      frame_type <= frame_type_next;
      length     <= length_next;
      count      <= count_next;
      amp        <= amp_next;
    end
  end

endmodule

// File: rtl/slpd_out_reg.sv
// Output register of the deframer: holds one finished frame record for the master side.
// Uses slpd_pkg for the result record.
module slpd_out_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         res_load,
  input  slpd_pkg::result_t            res,
  output logic                         res_ready,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [slpd_pkg::DATA_W-1:0]  m_tdata,  // [7:0] frame_type, [23:8] payload_length,
                                                 // [31:24] trailer_value, [47:32] amplitude
  output logic [0:0]                   m_tuser   // [0] amplitude_valid
);

  logic              valid;
  slpd_pkg::result_t hold;

  assign res_ready = !valid || m_tready;
  assign m_tvalid  = valid;
  assign m_tdata   = {hold.amplitude, hold.trailer_value, hold.payload_length,
                      hold.frame_type};
  assign m_tuser   = hold.amplitude_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      hold <= res;
    end
  end

endmodule

// File: rtl/slpd_checker.sv
// Port-level checks for the sync/length packet deframer, bound to the top level.
// Uses slpd_pkg for the amplitude frame type and the data width.
module slpd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [slpd_pkg::DATA_W-1:0]  m_tdata,
  input logic [0:0]                   m_tuser
);

  // A record waiting on the receiver is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output record changed while stalled");

  // Reset leaves no record pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("record pending after reset");

  // Without a valid flag the amplitude is zero.
  a_amp_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[47:32] == 16'd0)
    else $error("amplitude not zero while flagged invalid");

  // A valid amplitude only comes from a type-1 frame with two or more payload bytes.
  a_amp_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[7:0] == slpd_pkg::AMP_TYPE && m_tdata[23:8] >= 16'd2)
    else $error("amplitude flagged valid on the wrong frame");

  // A record that shows up on an empty output stage comes from an input transfer
  // that went through the input register and the output register without waiting.
  a_rec_source: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid ##1 m_tvalid |-> $past(s_tvalid && s_tready, 2))
    else $error("record appeared without input");

endmodule

bind sync_length_packet_deframer slpd_checker u_slpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
